[design/assert_macros.svh]
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[design/ffpa_pkg.sv]
// Types, constants and the microcode table of the first-fit pool allocator.
`timescale 1ns / 1ps
package ffpa_pkg;

	localparam int POOL_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_W       = $clog2(POOL_BYTES);
	localparam int FIELD_W      = 13;
	localparam int PTR_W        = FIELD_W + 1;
	localparam int OFS_W        = 12;
	localparam int STEP_W       = 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_POOL_SIZE = 1'b0;

	typedef struct packed {
		logic               operation;
		logic [FIELD_W-1:0] request_bytes;
		logic [OFS_W-1:0]   release_offset;
	} ffpa_in_t;

	typedef struct packed {
		logic [OFS_W-1:0] data_offset;
		logic             out_of_memory;
	} ffpa_out_t;

	// One header: payload size and distance to the next header.
	typedef struct packed {
		logic [FIELD_W-1:0] size;
		logic [FIELD_W-1:0] next;
	} ffpa_hdr_t;

	// Access request to the header store.
	typedef struct packed {
		logic               size_we;
		logic               next_we;
		logic [ADDR_W-1:0]  wr_addr;
		logic [FIELD_W-1:0] size_wd;
		logic [FIELD_W-1:0] next_wd;
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
	} ffpa_hdr_req_t;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [3:0]        act_t;
	typedef logic [2:0]        cond_t;

	// Datapath actions
	localparam act_t ACT_NONE      = 4'd0;
	localparam act_t ACT_LATCH     = 4'd1;
	localparam act_t ACT_READ      = 4'd2;
	localparam act_t ACT_STEP      = 4'd3;
	localparam act_t ACT_LINK      = 4'd4;
	localparam act_t ACT_PLACE     = 4'd5;
	localparam act_t ACT_SPLIT     = 4'd6;
	localparam act_t ACT_FILL      = 4'd7;
	localparam act_t ACT_FREE      = 4'd8;
	localparam act_t ACT_EMIT_AT   = 4'd9;
	localparam act_t ACT_EMIT_OOM  = 4'd10;
	localparam act_t ACT_EMIT_ZERO = 4'd11;

	// Jump conditions
	localparam cond_t COND_NONE      = 3'd0;
	localparam cond_t COND_ALWAYS    = 3'd1;
	localparam cond_t COND_IS_FREE   = 3'd2;
	localparam cond_t COND_WALK_DONE = 3'd3;
	localparam cond_t COND_NEXT_ZERO = 3'd4;
	localparam cond_t COND_FIT       = 3'd5;
	localparam cond_t COND_NO_ROOM   = 3'd6;
	localparam cond_t COND_AT_BAD    = 3'd7;

	// Program addresses
	localparam step_t S_IDLE   = 4'd0;
	localparam step_t S_WALK   = 4'd1;
	localparam step_t S_LOOK   = 4'd2;
	localparam step_t S_TEST   = 4'd3;
	localparam step_t S_STEP   = 4'd4;
	localparam step_t S_APPEND = 4'd5;
	localparam step_t S_LINK   = 4'd6;
	localparam step_t S_PLACE  = 4'd7;
	localparam step_t S_SPLIT  = 4'd8;
	localparam step_t S_RANGE  = 4'd9;
	localparam step_t S_FILL   = 4'd10;
	localparam step_t S_DONE   = 4'd11;
	localparam step_t S_OOM    = 4'd12;
	localparam step_t S_FREE   = 4'd13;
	localparam step_t S_ZERO   = 4'd14;

	typedef struct packed {
		logic  in_rdy;
		logic  out_wr;
		act_t  act;
		cond_t cond;
		step_t target;
	} ffpa_ucw_t;

	function automatic ffpa_ucw_t ffpa_ucode(input step_t s);
		ffpa_ucw_t w;
		w = '{in_rdy: 1'b0, out_wr: 1'b0, act: ACT_NONE, cond: COND_ALWAYS, target: S_IDLE};
		unique case (s)
			S_IDLE:   w = '{1'b1, 1'b0, ACT_LATCH,     COND_IS_FREE,   S_FREE};
			S_WALK:   w = '{1'b0, 1'b0, ACT_READ,      COND_WALK_DONE, S_APPEND};
			S_LOOK:   w = '{1'b0, 1'b0, ACT_NONE,      COND_NEXT_ZERO, S_APPEND};
			S_TEST:   w = '{1'b0, 1'b0, ACT_NONE,      COND_FIT,       S_SPLIT};
			S_STEP:   w = '{1'b0, 1'b0, ACT_STEP,      COND_ALWAYS,    S_WALK};
			S_APPEND: w = '{1'b0, 1'b0, ACT_NONE,      COND_NO_ROOM,   S_OOM};
			S_LINK:   w = '{1'b0, 1'b0, ACT_LINK,      COND_NONE,      S_IDLE};
			S_PLACE:  w = '{1'b0, 1'b0, ACT_PLACE,     COND_ALWAYS,    S_DONE};
			S_SPLIT:  w = '{1'b0, 1'b0, ACT_SPLIT,     COND_NONE,      S_IDLE};
			S_RANGE:  w = '{1'b0, 1'b0, ACT_NONE,      COND_AT_BAD,    S_OOM};
			S_FILL:   w = '{1'b0, 1'b0, ACT_FILL,      COND_NONE,      S_IDLE};
			S_DONE:   w = '{1'b0, 1'b1, ACT_EMIT_AT,   COND_ALWAYS,    S_IDLE};
			S_OOM:    w = '{1'b0, 1'b1, ACT_EMIT_OOM,  COND_ALWAYS,    S_IDLE};
			S_FREE:   w = '{1'b0, 1'b0, ACT_FREE,      COND_NONE,      S_IDLE};
			S_ZERO:   w = '{1'b0, 1'b1, ACT_EMIT_ZERO, COND_ALWAYS,    S_IDLE};
			default:  w = '{1'b0, 1'b0, ACT_NONE,      COND_ALWAYS,    S_IDLE};
		endcase
		return w;
	endfunction

endpackage

[design/ffpa_hdr_store.sv]
// Header store: size and next-link arrays with separate write enables.
`timescale 1ns / 1ps
module ffpa_hdr_store import ffpa_pkg::*; (
	input  logic          clk,
	input  ffpa_hdr_req_t req,
	output ffpa_hdr_t     rd
);

	logic [FIELD_W-1:0] size_mem [POOL_BYTES];
	logic [FIELD_W-1:0] next_mem [POOL_BYTES];
	logic [FIELD_W-1:0] size_rd_q;
	logic [FIELD_W-1:0] next_rd_q;

	always_ff @(posedge clk) begin
		if (req.size_we) begin
			size_mem[req.wr_addr] <= req.size_wd;
		end
		if (req.rd_en) begin
			size_rd_q <= size_mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.next_we) begin
			next_mem[req.wr_addr] <= req.next_wd;
		end
		if (req.rd_en) begin
			next_rd_q <= next_mem[req.rd_addr];
		end
	end

	assign rd.size = size_rd_q;
	assign rd.next = next_rd_q;

endmodule

[design/first_fit_pool_allocator_unit.sv]
// Top level of the first-fit pool allocator: microcode sequencer, datapath and APB register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// First-fit allocator over a 4096-byte pool of relative offsets, each block led by a
// 16-byte in-band header (size, distance to next header). Allocate walks the header
// chain from offset 0, reuses a freed span or splits a live block's tail when it fits,
// else appends at the top pointer; it returns header offset + 16, or 0 with
// out_of_memory set. Free zeroes the size of the header 16 bytes below release_offset.
// Sequencing: an input transfers only in the idle step of the program. A free updates the
// header in the free step, registers its result in the zero step and returns to idle. An
// allocate visits each header in the read, look, test and step steps of the microcode
// program, because the header store has one registered read port. A walk that reaches the
// top or a zero link goes through append, then out-of-memory or link, place and done; a
// fitting gap goes through split and range, then out-of-memory or fill and done. A result
// waits in an output register, so the next input is taken while it is still pending. No
// pool clearing runs after reset: headers are written before the walk ever reads them.
// Register pool_size (byte address 0, reset 4096) caps the pool in use.
module first_fit_pool_allocator_unit import ffpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ffpa_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ffpa_out_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Sequencer state
	step_t     step_q;
	step_t     step_d;
	ffpa_ucw_t cw;
	logic      hold;
	logic      take;

	// Datapath registers
	logic [PTR_W-1:0]   p_q;
	logic [PTR_W-1:0]   at_q;
	logic [FIELD_W-1:0] rest_q;
	logic [FIELD_W-1:0] req_q;
	logic [OFS_W-1:0]   rel_q;
	logic [FIELD_W-1:0] top_q;
	logic [FIELD_W-1:0] pool_size_q;

	// Output register
	logic      out_valid_q;
	ffpa_out_t out_data_q;
	ffpa_out_t out_next;

	// Header store
	ffpa_hdr_req_t hreq;
	ffpa_hdr_t     hdr;

	// Derived datapath values
	logic [PTR_W-1:0]   total;
	logic [PTR_W-1:0]   used;
	logic [PTR_W-1:0]   keep;
	logic [PTR_W-1:0]   hnext;
	logic [FIELD_W-1:0] limit;
	logic               walk_done;
	logic               fit;
	logic               no_room;
	logic               link_ok;

	assign cw = ffpa_ucode(step_q);

	// Stall the program while waiting for an input or for room in the output register.
	assign hold = (cw.in_rdy && !in_valid) || (cw.out_wr && out_valid_q && !out_ready);

	assign total = {1'b0, req_q} + PTR_W'(HEADER_BYTES);
	assign hnext = {1'b0, hdr.next};
	assign keep  = {1'b0, hdr.size} + PTR_W'(HEADER_BYTES);
	assign used  = (hdr.size != '0) ? (keep + PTR_W'(HEADER_BYTES)) : keep;
	assign limit = (pool_size_q < FIELD_W'(POOL_BYTES)) ? pool_size_q : FIELD_W'(POOL_BYTES);

	// Walk ends at the top pointer or past the pool.
	assign walk_done = (({1'b0, p_q} + (PTR_W + 1)'(1)) >= {2'b0, top_q})
		|| (p_q >= PTR_W'(POOL_BYTES));
	// Gap after the used part of this block must hold payload plus one header.
	assign fit       = (hnext >= used) && ((hnext - used) >= total);
	assign no_room   = ({2'b0, top_q} + {1'b0, total}) >= {2'b0, limit};
	// Link the old last block only when its header lies at or below the top and inside the pool.
	assign link_ok   = (p_q <= {1'b0, top_q}) && (p_q < PTR_W'(POOL_BYTES));

	always_comb begin
		unique case (cw.cond)
			COND_NONE:      take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_IS_FREE:   take = (in_data.operation == OP_FREE);
			COND_WALK_DONE: take = walk_done;
			COND_NEXT_ZERO: take = (hdr.next == '0);
			COND_FIT:       take = fit;
			COND_NO_ROOM:   take = no_room;
			COND_AT_BAD:    take = (at_q >= PTR_W'(POOL_BYTES));
			default:        take = 1'b0;
		endcase
	end

	always_comb begin
		priority if (hold) begin
			step_d = step_q;
		end else if (take) begin
			step_d = cw.target;
		end else begin
			step_d = step_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Header store access
	always_comb begin
		hreq         = '0;
		hreq.rd_addr = p_q[ADDR_W-1:0];
		if (!hold) begin
			unique case (cw.act)
				ACT_READ: begin
					hreq.rd_en = 1'b1;
				end
				ACT_LINK: begin
					hreq.next_we = link_ok;
					hreq.wr_addr = p_q[ADDR_W-1:0];
					hreq.next_wd = top_q - p_q[FIELD_W-1:0];
				end
				ACT_PLACE: begin
					hreq.size_we = 1'b1;
					hreq.next_we = 1'b1;
					hreq.wr_addr = top_q[ADDR_W-1:0];
					hreq.size_wd = req_q;
					hreq.next_wd = '0;
				end
				ACT_SPLIT: begin
					// Shrink a live block to its payload; the split-off tail follows it.
					hreq.next_we = (hdr.size != '0);
					hreq.wr_addr = p_q[ADDR_W-1:0];
					hreq.next_wd = keep[FIELD_W-1:0];
				end
				ACT_FILL: begin
					hreq.size_we = 1'b1;
					hreq.next_we = 1'b1;
					hreq.wr_addr = at_q[ADDR_W-1:0];
					hreq.size_wd = req_q;
					hreq.next_wd = rest_q;
				end
				ACT_FREE: begin
					// Drop a release offset that has no room for a header below it.
					hreq.size_we = (rel_q >= OFS_W'(HEADER_BYTES));
					hreq.wr_addr = ADDR_W'(rel_q - OFS_W'(HEADER_BYTES));
					hreq.size_wd = '0;
				end
				default: begin
				end
			endcase
		end
	end

	ffpa_hdr_store u_hdr_store (
		.clk (clk),
		.req (hreq),
		.rd  (hdr)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		if (!hold) begin
			unique case (cw.act)
				ACT_LATCH: begin
					p_q   <= '0;
					req_q <= in_data.request_bytes;
					rel_q <= in_data.release_offset;
				end
				ACT_STEP: begin
					p_q <= p_q + hnext;
				end
				ACT_PLACE: begin
					at_q <= {1'b0, top_q};
				end
				ACT_SPLIT: begin
					if (hdr.size != '0) begin
						at_q   <= p_q + keep;
						rest_q <= hdr.next - keep[FIELD_W-1:0];
					end else begin
						at_q   <= p_q;
						rest_q <= hdr.next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Top pointer advances on append only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (!hold && cw.act == ACT_PLACE) begin
			top_q <= top_q + total[FIELD_W-1:0];
		end
	end

	// Output register
	always_comb begin
		unique case (cw.act)
			ACT_EMIT_AT:  out_next = '{data_offset: at_q[OFS_W-1:0] + OFS_W'(HEADER_BYTES),
				out_of_memory: 1'b0};
			ACT_EMIT_OOM: out_next = '{data_offset: '0, out_of_memory: 1'b1};
			default:      out_next = '{data_offset: '0, out_of_memory: 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!hold && cw.out_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && cw.out_wr) begin
			out_data_q <= out_next;
		end
	end

	assign in_ready  = cw.in_rdy;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= FIELD_W'(POOL_BYTES);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_POOL_SIZE) begin
			pool_size_q <= pwdata[FIELD_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_POOL_SIZE) ? {{(32 - FIELD_W){1'b0}}, pool_size_q} : '0;
	assign pready = 1'b1;

	// Appends only succeed below the pool limit, so the top never reaches the pool end.
	`ASSERT_CLK(a_top_in_pool, top_q < FIELD_W'(POOL_BYTES), "top pointer left the pool")
	// A new result only comes from an emit step of the program.
	`ASSERT_CLK(a_out_from_emit, $rose(out_valid_q) |-> $past(cw.out_wr), "result without emit step")
	// The header store is never written while waiting for input.
	`ASSERT_NEVER(a_no_write_idle, (step_q == S_IDLE) && (hreq.size_we || hreq.next_we),
		"header write while idle")

endmodule
